>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising edge, off while reset is high.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Overlapping implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/basc_pkg.sv
// Package for the binary-angle sine/cosine block: constants and stage types.
// No dependencies.
`timescale 1ns / 1ps

package basc_pkg;

  localparam int OUT_BITS_DEF = 16;

  localparam logic [15:0] QUARTER = 16'h4000;
  localparam logic [15:0] HALF    = 16'h8000;

  // round(pi * 2^30)
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Reciprocals for exact constant division: /3 (>>33), /5 (>>34), /21 (>>32)
  localparam logic [31:0] RECIP3  = 32'hAAAAAAAB;
  localparam logic [31:0] RECIP5  = 32'hCCCCCCCD;
  localparam logic [27:0] RECIP21 = 28'd204522253;

  // Accept edge to the edge at which the strobe is sampled
  localparam int LATENCY = 11;

  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [14:0] q;
  } fold_t;

  typedef struct packed {
    logic        valid;
    logic        neg;
    logic [31:0] s;
  } poly_t;

endpackage

>>> hw/rtl/binary_angle_sine_cosine_top.sv
// Binary-angle sine/cosine, 7th-order Taylor evaluation, fully pipelined.
// Depends on basc_pkg, basc_fold, basc_poly, basc_round, assert_macros.svh.
// An item is taken on every cycle with start high and busy low; busy is high
// only during reset. The result appears on value with done high for one
// cycle, in issue order. One item per cycle is sustained; the depth is set
// by the eight multiply stages of the polynomial pipeline plus the fold,
// term-sum and rounding registers.
// Nothing stalls: results must be captured on the cycle done is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module binary_angle_sine_cosine_top #(
  parameter int OUT_BITS = basc_pkg::OUT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func,
  input  logic [15:0]                angle,
  output logic                       done,
  output logic signed [OUT_BITS-1:0] value
);

  logic            take;
  basc_pkg::fold_t fold_q;
  basc_pkg::poly_t poly_q;

  assign busy = rst;
  assign take = start & ~busy;

  basc_fold u_fold (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .func  (func),
    .angle (angle),
    .out   (fold_q)
  );

  basc_poly u_poly (
    .clk (clk),
    .rst (rst),
    .in  (fold_q),
    .out (poly_q)
  );

  basc_round #(
    .OUT_BITS (OUT_BITS)
  ) u_round (
    .clk   (clk),
    .rst   (rst),
    .in    (poly_q),
    .done  (done),
    .value (value)
  );

  `ASSERT_IMPL(a_latency, clk, rst, done, $past(take, basc_pkg::LATENCY), "result without item")

endmodule

>>> hw/rtl/basc_fold.sv
// Input stage: cosine offset and quadrant fold to a first-quadrant angle.
// Depends on basc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module basc_fold (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic                 func,
  input  logic [15:0]          angle,
  output basc_pkg::fold_t      out
);

  logic [15:0] a;
  logic [15:0] h;
  logic        neg_c;
  logic [15:0] q_c;

  always_comb begin
    a = func ? (angle + basc_pkg::QUARTER) : angle;
    neg_c = (a > basc_pkg::HALF);
    h = neg_c ? (a - basc_pkg::HALF) : a;
    q_c = (h <= basc_pkg::QUARTER) ? h : (basc_pkg::HALF - h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= take;
    end
    out.neg <= neg_c;
    out.q   <= q_c[14:0];
  end

  `ASSERT_IMPL(a_fold_range, clk, rst, out.valid, ({1'b0, out.q} <= basc_pkg::QUARTER), "q range")

endmodule

>>> hw/rtl/basc_poly.sv
// Taylor polynomial pipeline: x, x^2, x^3/6, x^5/120, x^7/5040 in Q2.30.
// One multiply per stage; constant divisions by reciprocal. Depends on basc_pkg.
`timescale 1ns / 1ps

module basc_poly (
  input  logic             clk,
  input  logic             rst,
  input  basc_pkg::fold_t  in,
  output basc_pkg::poly_t  out
);

  logic [8:1] v;
  logic [8:1] n;

  logic [45:0] prod;
  logic [30:0] x2s, x3s, x4s, x5s, x6s, x7s, x8s;
  logic [61:0] xx;
  logic [31:0] sq3, sq4, sq5, sq6;
  logic [62:0] p3;
  logic [63:0] m3;
  logic [29:0] t3_5, t3_6, t3_7, t3_8;
  logic [61:0] p5;
  logic [61:0] m5;
  logic [27:0] t5_7, t5_8;
  logic [59:0] p7;
  logic [56:0] m7;

  logic [45:0] x_sum;
  logic [30:0] x_c;
  logic [61:0] sq_sum;
  logic [31:0] sq_c;
  logic [62:0] u_sum;
  logic [32:0] u_c;
  logic [29:0] t3_c;
  logic [61:0] v_sum;
  logic [31:0] v_c;
  logic [27:0] t5_c;
  logic [59:0] w_sum;
  logic [29:0] w_c;
  logic [24:0] t7_c;
  logic [31:0] s_c;

  always_comb begin
    x_sum  = prod + 46'd16384;
    x_c    = x_sum[45:15];
    sq_sum = xx + (62'd1 << 29);
    sq_c   = sq_sum[61:30];
    u_sum  = p3 + (63'd3 << 30);
    u_c    = u_sum[62:30];
    t3_c   = m3[62:33];
    v_sum  = p5 + (62'd10 << 30);
    v_c    = v_sum[61:30];
    t5_c   = m5[61:34];
    w_sum  = p7 + (60'd21 << 30);
    w_c    = w_sum[59:30];
    t7_c   = m7[56:32];
    s_c    = {1'b0, x8s} - {2'b0, t3_8} + {4'b0, t5_8} - {7'b0, t7_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out.valid <= 1'b0;
    end else begin
      v         <= {v[7:1], in.valid};
      out.valid <= v[8];
    end
    n <= {n[7:1], in.neg};
    // x = q*pi
    prod <= {31'b0, in.q} * {14'b0, basc_pkg::PI_Q30};
    // x^2
    x2s  <= x_c;
    xx   <= {31'b0, x_c} * {31'b0, x_c};
    // x^3
    x3s  <= x2s;
    sq3  <= sq_c;
    p3   <= {32'b0, x2s} * {31'b0, sq_c};
    // /6
    x4s  <= x3s;
    sq4  <= sq3;
    m3   <= {32'b0, u_c[32:1]} * {32'b0, basc_pkg::RECIP3};
    // t3 * x^2
    x5s  <= x4s;
    sq5  <= sq4;
    t3_5 <= t3_c;
    p5   <= {32'b0, t3_c} * {30'b0, sq4};
    // /20
    x6s  <= x5s;
    sq6  <= sq5;
    t3_6 <= t3_5;
    m5   <= {32'b0, v_c[31:2]} * {30'b0, basc_pkg::RECIP5};
    // t5 * x^2
    x7s  <= x6s;
    t3_7 <= t3_6;
    t5_7 <= t5_c;
    p7   <= {32'b0, t5_c} * {28'b0, sq6};
    // /42
    x8s  <= x7s;
    t3_8 <= t3_7;
    t5_8 <= t5_7;
    m7   <= {28'b0, w_c[29:1]} * {29'b0, basc_pkg::RECIP21};
    // sum of terms
    out.neg <= n[8];
    out.s   <= s_c;
  end

endmodule

>>> hw/rtl/basc_round.sv
// Output stage: Q1.(OUT_BITS-1) rounding, clamp and sign.
// Depends on basc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module basc_round #(
  parameter int OUT_BITS = basc_pkg::OUT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  basc_pkg::poly_t            in,
  output logic                       done,
  output logic signed [OUT_BITS-1:0] value
);

  localparam int          SH   = 32 - OUT_BITS;
  localparam logic [32:0] RND  = (33'd1 << SH) >> 1;
  localparam logic [32:0] MAXV = (33'd1 << (OUT_BITS - 1)) - 33'd1;

  logic [32:0]         sum;
  logic [32:0]         mag;
  logic [32:0]         mag_c;
  logic [OUT_BITS-1:0] res;
  logic [OUT_BITS-1:0] value_next;

  always_comb begin
    sum        = {in.s, 1'b0} + RND;
    mag        = sum >> SH;
    mag_c      = (mag > MAXV) ? MAXV : mag;
    res        = mag_c[OUT_BITS-1:0];
    value_next = in.neg ? (~res + 1'b1) : res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in.valid;
    end
    value <= value_next;
  end

  `ASSERT_IMPL(a_poly_range, clk, rst, in.valid, (in.s[31:30] == 2'b00), "sum outside [0,1)")

endmodule
